// ----- src/rbm_pkg.sv -----
`default_nettype none

package rbm_pkg;

    // Field widths
    localparam int unsigned OP_W     = 3;
    localparam int unsigned SEL_W    = 2;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned COLOR_W  = 3;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned CH_W     = 5;

    // Arithmetic widths: sum of three channels, channel*level, full numerator,
    // denominator sum*LEVEL_MAX and the aligned divisor for an 8-bit quotient
    localparam int unsigned SUM_W    = CH_W + 2;
    localparam int unsigned PROD_W   = CH_W + LEVEL_W;
    localparam int unsigned NUM_W    = PROD_W + DUTY_W;
    localparam int unsigned DEN_W    = SUM_W + LEVEL_W;
    localparam int unsigned DSH_W    = DEN_W + DUTY_W - 1;
    localparam int unsigned STEP_W   = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_NEXT     = 3'd0;
    localparam logic [OP_W-1:0] OP_BRIGHTER = 3'd1;
    localparam logic [OP_W-1:0] OP_DIMMER   = 3'd2;
    localparam logic [OP_W-1:0] OP_CYCLE    = 3'd3;
    localparam logic [OP_W-1:0] OP_NUDGE    = 3'd4;
    localparam logic [OP_W-1:0] OP_OFF      = 3'd5;

    // Channel select codes
    localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;

    // Nudge direction: up, or anything with the sign bit set means down
    localparam logic [DIR_W-1:0] DIR_UP = 2'b01;

    // Colour indexes
    localparam logic [COLOR_W-1:0] COLOR_CUSTOM = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_FIRST  = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_LAST   = 3'd6;

    // Reset values
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 8'd225;
    localparam logic [CH_W-1:0]   CUSTOM_RESET     = 5'd15;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // One scaling job handed from the front to the back
    typedef struct packed {
        logic                lit;
        rgb_t                rgb;
        logic [COLOR_W-1:0]  color;
        logic [LEVEL_W-1:0]  level;
    } job_t;

    // Fixed preset colours; anything that is not a preset reads as black
    function automatic rgb_t preset_rgb(input logic [COLOR_W-1:0] idx);
        rgb_t c;
        c = '{red: 5'd0, green: 5'd0, blue: 5'd0};
        case (idx)
            3'd1:    c = '{red: 5'd22, green: 5'd30, blue: 5'd30};
            3'd2:    c = '{red: 5'd30, green: 5'd0,  blue: 5'd0};
            3'd3:    c = '{red: 5'd0,  green: 5'd8,  blue: 5'd30};
            3'd4:    c = '{red: 5'd0,  green: 5'd30, blue: 5'd0};
            3'd5:    c = '{red: 5'd30, green: 5'd4,  blue: 5'd30};
            3'd6:    c = '{red: 5'd0,  green: 5'd30, blue: 5'd24};
            default: c = '{red: 5'd0,  green: 5'd0,  blue: 5'd0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/rbm_front.sv -----
`default_nettype none

module rbm_front #(
    parameter int unsigned LEVEL_MAX   = 10,
    parameter int unsigned CHANNEL_MAX = 31
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [rbm_pkg::OP_W-1:0]    op,
    input  wire logic [rbm_pkg::SEL_W-1:0]   channel,
    input  wire logic [rbm_pkg::DIR_W-1:0]   direction,
    output logic                             job_push,
    output rbm_pkg::job_t                    job,
    input  wire logic                        job_full
);

    localparam logic [rbm_pkg::LEVEL_W-1:0] LVL_MAX = rbm_pkg::LEVEL_W'(LEVEL_MAX);
    localparam logic [rbm_pkg::CH_W-1:0]    CH_MAX  = rbm_pkg::CH_W'(CHANNEL_MAX);

    logic [rbm_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [rbm_pkg::LEVEL_W-1:0] level_reg, level_next;
    rbm_pkg::rgb_t               custom_reg, custom_next;
    logic                        accept;
    logic                        emit;
    logic                        lit;
    logic [rbm_pkg::LEVEL_W:0]   level_inc;

    // Step one custom channel, saturating at zero and at the channel maximum
    function automatic logic [rbm_pkg::CH_W-1:0] nudge(
        input logic [rbm_pkg::CH_W-1:0]  c,
        input logic [rbm_pkg::DIR_W-1:0] d
    );
        logic [rbm_pkg::CH_W-1:0] r;
        r = c;
        if (d == rbm_pkg::DIR_UP) begin
            if (c < CH_MAX) begin
                r = c + 1'b1;
            end
        end else if (d[rbm_pkg::DIR_W-1]) begin
            if (c != '0) begin
                r = c - 1'b1;
            end
        end
        return r;
    endfunction

    assign full      = job_full;
    assign accept    = push && !job_full;
    assign level_inc = {1'b0, level_reg} + 1'b1;

    // Decode the event and work out the new state
    always_comb
    begin
        color_next  = color_reg;
        level_next  = level_reg;
        custom_next = custom_reg;
        emit        = 1'b0;
        lit         = 1'b1;
        unique case (op)
            rbm_pkg::OP_NEXT:
            begin
                color_next = (color_reg >= rbm_pkg::COLOR_LAST) ? rbm_pkg::COLOR_FIRST
                                                                : color_reg + 1'b1;
                emit = 1'b1;
            end
            rbm_pkg::OP_BRIGHTER:
            begin
                if (level_reg < LVL_MAX) begin
                    level_next = level_reg + 1'b1;
                end
                emit = 1'b1;
            end
            rbm_pkg::OP_DIMMER:
            begin
                if (level_reg != '0) begin
                    level_next = level_reg - 1'b1;
                end
                emit = 1'b1;
            end
            rbm_pkg::OP_CYCLE:
            begin
                level_next = (level_inc > {1'b0, LVL_MAX}) ? '0
                                                           : level_inc[rbm_pkg::LEVEL_W-1:0];
                emit = 1'b1;
            end
            rbm_pkg::OP_NUDGE:
            begin
                unique case (channel)
                    rbm_pkg::SEL_GREEN:
                        custom_next.green = nudge(custom_reg.green, direction);
                    rbm_pkg::SEL_BLUE:
                        custom_next.blue = nudge(custom_reg.blue, direction);
                    default:
                        custom_next.red = nudge(custom_reg.red, direction);
                endcase
            end
            rbm_pkg::OP_OFF:
            begin
                lit  = 1'b0;
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Build the scaling job from the state after the event
    always_comb
    begin
        job.lit   = lit;
        job.rgb   = (color_next == rbm_pkg::COLOR_CUSTOM) ? custom_next
                                                          : rbm_pkg::preset_rgb(color_next);
        job.color = color_next;
        job.level = level_next;
        job_push  = accept && emit;
    end

    // Hold the state, advance it on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            color_reg  <= rbm_pkg::COLOR_CUSTOM;
            level_reg  <= '0;
            custom_reg <= '{red: rbm_pkg::CUSTOM_RESET, green: rbm_pkg::CUSTOM_RESET,
                            blue: rbm_pkg::CUSTOM_RESET};
        end else if (accept) begin
            color_reg  <= color_next;
            level_reg  <= level_next;
            custom_reg <= custom_next;
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_MAX)
        else $error("brightness level beyond its maximum");

    a_no_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(color_reg) && $stable(level_reg) && $stable(custom_reg))
        else $error("state moved without a transaction");

endmodule

`default_nettype wire

// ----- src/rbm_fifo.sv -----
`default_nettype none

module rbm_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire rbm_pkg::job_t  wr_data,
    output logic                wr_full,
    input  wire logic           rd_en,
    output rbm_pkg::job_t       rd_data,
    output logic                rd_empty
);

    localparam int unsigned DEPTH = 2;

    rbm_pkg::job_t mem [DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_wr;
    logic          do_rd;

    assign wr_full  = (count_reg == 2'(DEPTH));
    assign rd_empty = (count_reg == '0);
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && !rd_empty;
    assign rd_data  = mem[rd_ptr_reg];

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/rbm_back.sv -----
`default_nettype none

module rbm_back #(
    parameter int unsigned LEVEL_MAX = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rbm_pkg::DUTY_W-1:0]    duty_limit,
    input  wire logic                          job_empty,
    input  wire rbm_pkg::job_t                 job,
    output logic                               job_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rbm_pkg::DUTY_W-1:0]         duty_red,
    output logic [rbm_pkg::DUTY_W-1:0]         duty_green,
    output logic [rbm_pkg::DUTY_W-1:0]         duty_blue,
    output logic [rbm_pkg::COLOR_W-1:0]        color_index,
    output logic [rbm_pkg::LEVEL_W-1:0]        level
);

    localparam int unsigned LANES = 3;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [rbm_pkg::STEP_W-1:0] LAST_STEP = rbm_pkg::STEP_W'(rbm_pkg::DUTY_W - 1);

    logic [2:0]                    state_reg, state_next;
    rbm_pkg::job_t                 job_reg;
    logic                          zero_reg;
    logic [rbm_pkg::DEN_W-1:0]     den_reg;
    logic [rbm_pkg::DSH_W-1:0]     dsh_reg;
    logic [rbm_pkg::STEP_W-1:0]    step_reg;
    logic [rbm_pkg::PROD_W-1:0]    prod_reg [LANES];
    logic [rbm_pkg::NUM_W-1:0]     rem_reg  [LANES];
    logic [rbm_pkg::DUTY_W-1:0]    quo_reg  [LANES];
    logic [rbm_pkg::DUTY_W-1:0]    duty_fin [LANES];
    logic [rbm_pkg::CH_W-1:0]      chan     [LANES];
    logic [rbm_pkg::SUM_W-1:0]     sum;
    logic                          out_valid_reg;
    logic [rbm_pkg::DUTY_W-1:0]    red_reg, green_reg, blue_reg;
    logic [rbm_pkg::COLOR_W-1:0]   color_reg;
    logic [rbm_pkg::LEVEL_W-1:0]   level_reg;
    logic                          load_out;

    assign chan[0] = job_reg.rgb.red;
    assign chan[1] = job_reg.rgb.green;
    assign chan[2] = job_reg.rgb.blue;
    assign sum     = rbm_pkg::SUM_W'(chan[0]) + rbm_pkg::SUM_W'(chan[1])
                   + rbm_pkg::SUM_W'(chan[2]);

    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || pop);

    // Clamp each quotient to the limit, force zero when off or black
    always_comb
    begin
        for (int i = 0; i < LANES; i++) begin
            duty_fin[i] = zero_reg ? '0
                        : ((quo_reg[i] > duty_limit) ? duty_limit : quo_reg[i]);
        end
    end

    // Sequence one job: multiply, multiply, eight divide steps, hand over
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!job_empty) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (step_reg == LAST_STEP) state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: products, restoring division with a shared aligned divisor
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
            end
            ST_MUL:
            begin
                for (int i = 0; i < LANES; i++) begin
                    prod_reg[i] <= rbm_pkg::PROD_W'(chan[i])
                                 * rbm_pkg::PROD_W'(job_reg.level);
                end
                den_reg  <= rbm_pkg::DEN_W'(sum) * rbm_pkg::DEN_W'(LEVEL_MAX);
                zero_reg <= !job_reg.lit || (sum == '0);
            end
            ST_SCALE:
            begin
                for (int i = 0; i < LANES; i++) begin
                    rem_reg[i] <= rbm_pkg::NUM_W'(prod_reg[i])
                                * rbm_pkg::NUM_W'(duty_limit);
                    quo_reg[i] <= '0;
                end
                dsh_reg  <= {den_reg, {(rbm_pkg::DUTY_W-1){1'b0}}};
                step_reg <= '0;
            end
            ST_DIV:
            begin
                for (int i = 0; i < LANES; i++) begin
                    if ({1'b0, rem_reg[i]} >= dsh_reg) begin
                        rem_reg[i] <= rem_reg[i] - dsh_reg[rbm_pkg::NUM_W-1:0];
                        quo_reg[i] <= {quo_reg[i][rbm_pkg::DUTY_W-2:0], 1'b1};
                    end else begin
                        quo_reg[i] <= {quo_reg[i][rbm_pkg::DUTY_W-2:0], 1'b0};
                    end
                end
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    // Result register: hold until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out) begin
            red_reg   <= duty_fin[0];
            green_reg <= duty_fin[1];
            blue_reg  <= duty_fin[2];
            color_reg <= job_reg.color;
            level_reg <= job_reg.level;
        end
    end

    assign empty       = !out_valid_reg;
    assign duty_red    = red_reg;
    assign duty_green  = green_reg;
    assign duty_blue   = blue_reg;
    assign color_index = color_reg;
    assign level       = level_reg;

    a_dark_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (level_reg == '0) |-> (red_reg == '0) && (green_reg == '0)
                                             && (blue_reg == '0))
        else $error("non-zero duty at brightness level zero");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished job not presented");

    a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (red_reg <= duty_limit) && (green_reg <= duty_limit)
                       && (blue_reg <= duty_limit))
        else $error("duty above the limit");

endmodule

`default_nettype wire

// ----- src/rgb_backlight_mixer.sv -----
`default_nettype none

// RGB backlight mixer. Each button event (push/full) updates the selected
// colour, brightness level or custom RGB triple at once; every event other
// than a custom nudge or an unknown code queues one result, read out through
// empty/pop. Once the back end picks up a job, the result goes through
// loading the job, two multiply stages (channel by level, then by the
// duty limit) and eight steps of a restoring divider that works the
// three channels side by side, then the load of the result register, which
// waits while an unpopped result is held. The back end takes no new job
// until it has handed over the last; a two-entry job queue lets up to two
// queued jobs wait while the back end is busy. cfg_wdata is the duty limit
// (reset 225) and must only be written while no event is in flight.
module rgb_backlight_mixer #(
    parameter int unsigned LEVEL_MAX   = 10,
    parameter int unsigned CHANNEL_MAX = 31
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [rbm_pkg::OP_W-1:0]      op,
    input  wire logic [rbm_pkg::SEL_W-1:0]     channel,
    input  wire logic [rbm_pkg::DIR_W-1:0]     direction,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rbm_pkg::DUTY_W-1:0]         duty_red,
    output logic [rbm_pkg::DUTY_W-1:0]         duty_green,
    output logic [rbm_pkg::DUTY_W-1:0]         duty_blue,
    output logic [rbm_pkg::COLOR_W-1:0]        color_index,
    output logic [rbm_pkg::LEVEL_W-1:0]        level,
    input  wire logic                          cfg_wen,
    input  wire logic [rbm_pkg::DUTY_W-1:0]    cfg_wdata
);

    logic [rbm_pkg::DUTY_W-1:0] duty_limit_reg;
    logic                       job_push;
    logic                       job_full;
    logic                       job_pop;
    logic                       job_empty;
    rbm_pkg::job_t              job_in;
    rbm_pkg::job_t              job_out;

    // Hold the duty limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            duty_limit_reg <= rbm_pkg::DUTY_LIMIT_RESET;
        end else if (cfg_wen) begin
            duty_limit_reg <= cfg_wdata;
        end
    end

    rbm_front #(
        .LEVEL_MAX   (LEVEL_MAX),
        .CHANNEL_MAX (CHANNEL_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .channel   (channel),
        .direction (direction),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    rbm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .wr_full  (job_full),
        .rd_en    (job_pop),
        .rd_data  (job_out),
        .rd_empty (job_empty)
    );

    rbm_back #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .duty_limit  (duty_limit_reg),
        .job_empty   (job_empty),
        .job         (job_out),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .duty_red    (duty_red),
        .duty_green  (duty_green),
        .duty_blue   (duty_blue),
        .color_index (color_index),
        .level       (level)
    );

endmodule

`default_nettype wire
